### sv/first_fit_block_allocator_top_defines.svh
// Assertion macros for the first-fit block allocator.
// Included by every module that carries concurrent checks; expects clk and arst_n in scope.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// plain property, checked every clock outside reset
`define FFA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition this cycle implies consequence next cycle
`define FFA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define FFA_ASSERT(lbl, prop, msg)
`define FFA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### sv/ffa_pkg.sv
// Shared types and defaults of the first-fit block allocator.
// No dependencies; used by ffa_slot_pool and the top level.
package ffa_pkg;

	localparam int ARENA_BYTES_DEF  = 4096;
	localparam int HEADER_BYTES_DEF = 24;
	localparam int MAX_BLOCKS_DEF   = 64;

	localparam int REQ_W = 13;
	localparam int OFF_W = 12;
	localparam int ST_W  = 3;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 3'd0,
		ST_NO_SPACE  = 3'd1,
		ST_ZERO      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// slot pool requests from the sequencer
	typedef struct packed {
		logic fetch; // prefetch top of free stack
		logic take;  // commit the current slot as used
		logic give;  // return give_idx to the pool
	} slot_ctl_t;

endpackage

### sv/ffa_entry_ram.sv
// Block table memory: one write port, one read port, registered read data.
// No dependencies.
module ffa_entry_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	parameter int IW    = 6
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [IW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### sv/ffa_slot_pool.sv
// Table slot pool: high-water mark plus a stack of released slots in memory.
// Depends on ffa_pkg and the assertion macro header.
`include "first_fit_block_allocator_top_defines.svh"
module ffa_slot_pool #(
	parameter int MAX_BLOCKS = 64,
	parameter int IW         = 6,
	parameter int CNT_W      = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ffa_pkg::slot_ctl_t ctl,
	input  logic [IW-1:0]     give_idx,
	output logic [IW-1:0]     slot,
	output logic              full
);
	import ffa_pkg::*;

	logic [IW-1:0]    stack_mem [MAX_BLOCKS];
	logic [IW-1:0]    top_q;
	logic [CNT_W-1:0] sp_q;
	logic [CNT_W-1:0] hwm_q;
	logic [CNT_W-1:0] sp_dec;

	assign sp_dec = sp_q - CNT_W'(1);
	assign slot   = (sp_q != '0) ? top_q : hwm_q[IW-1:0];
	assign full   = (sp_q == '0) && (hwm_q == CNT_W'(MAX_BLOCKS));

	always_ff @(posedge clk) begin
		if (ctl.give) begin
			stack_mem[sp_q[IW-1:0]] <= give_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fetch && sp_q != '0) begin
			top_q <= stack_mem[sp_dec[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q  <= '0;
			hwm_q <= '0;
		end else begin
			if (ctl.give) begin
				sp_q <= sp_q + CNT_W'(1);
			end else if (ctl.take) begin
				if (sp_q != '0) begin
					sp_q <= sp_dec;
				end else begin
					hwm_q <= hwm_q + CNT_W'(1);
				end
			end
		end
	end

	`FFA_ASSERT(a_sp_le_hwm, sp_q <= hwm_q, "free stack deeper than slots ever handed out")
	`FFA_ASSERT(a_hwm_bound, hwm_q <= CNT_W'(MAX_BLOCKS), "high-water mark past table depth")
	`FFA_ASSERT(a_take_ok, ctl.take |-> (!full && !ctl.give), "slot taken while full or during release")

endmodule

### sv/first_fit_block_allocator_top.sv
// First-fit block allocator, top level: request sequencer, block table, slot pool.
// Depends on ffa_pkg, ffa_entry_ram, ffa_slot_pool and the assertion macro header.
//
// Usage:
//   Input channel (in_valid/in_ready) carries command, request_bytes and
//   payload_offset; command 0 allocates request_bytes of payload, 1 frees
//   the block whose payload starts at payload_offset.
//   Output channel (out_valid/out_ready) returns one status/granted_offset
//   per request, in order.
//   Blocks sit in a linked list held in the block table memory, ordered by
//   address. Each request walks that list one table read per cycle, so the
//   cost is set by the single read port of the table memory.
//   Zero size, table full, empty-list free and empty-list allocate skip the walk.
//   The result shows up in the same cycle that in_ready rises again.
//   One request is in flight at a time; in_ready is high whenever the
//   sequencer is idle, even while the previous result still waits.
//   If the receiver stalls, a finished result waits in S_DONE until the
//   output register is free, and only then does the sequencer return to idle.
//   Reset empties the list and the slot pool at once; no clearing pass.
`include "first_fit_block_allocator_top_defines.svh"
module first_fit_block_allocator_top #(
	parameter int ARENA_BYTES  = ffa_pkg::ARENA_BYTES_DEF,
	parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
	parameter int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       command,
	input  logic [ffa_pkg::REQ_W-1:0]  request_bytes,
	input  logic [ffa_pkg::OFF_W-1:0]  payload_offset,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ffa_pkg::ST_W-1:0]   status,
	output logic [ffa_pkg::OFF_W-1:0]  granted_offset
);
	import ffa_pkg::*;

	// table index, arena address and compare widths
	localparam int IW    = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int AW    = $clog2(ARENA_BYTES + 1);
	localparam int CW    = ((AW > REQ_W + 1) ? AW : REQ_W + 1) + 1;
	localparam int EW    = 2 * AW + IW;

	localparam logic [CW-1:0] HDR_W   = CW'(HEADER_BYTES);
	localparam logic [CW-1:0] ARENA_W = CW'(ARENA_BYTES);

	typedef struct packed {
		logic [AW-1:0] start; // header offset
		logic [AW-1:0] len;   // payload length
		logic [IW-1:0] link;  // next block; self link marks the last
	} entry_t;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_A_HEAD = 8'b0000_0010,
		S_A_WALK = 8'b0000_0100,
		S_A_TAIL = 8'b0000_1000,
		S_PLACE  = 8'b0001_0000,
		S_RELINK = 8'b0010_0000,
		S_F_WALK = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t          state_q;

	// list registers
	logic [IW-1:0]   head_q;
	logic            empty_q;

	// request context
	logic [REQ_W-1:0] size_q;
	logic [OFF_W-1:0] off_q;
	logic [CW-1:0]    need_q;

	// walk context
	entry_t          cur_q;
	logic [IW-1:0]   cur_idx_q;
	logic [CW-1:0]   cur_end_q;
	logic [IW-1:0]   nxt_idx_q;
	entry_t          prev_q;
	logic [IW-1:0]   prev_idx_q;
	logic            first_q;

	// placement context
	logic [AW-1:0]   new_start_q;
	logic [IW-1:0]   new_link_q;
	logic            self_link_q;
	logic            head_ins_q;
	logic            relink_q;
	logic [IW-1:0]   slot_q;

	// pending and delivered result
	status_t         res_st_q;
	logic [OFF_W-1:0] res_off_q;
	logic            out_valid_q;
	status_t         out_st_q;
	logic [OFF_W-1:0] out_off_q;

	// memory and pool hookup
	logic            ram_wr;
	logic [IW-1:0]   ram_wa;
	entry_t          ram_wd;
	logic            ram_rd;
	logic [IW-1:0]   ram_ra;
	logic [EW-1:0]   ram_rd_data;
	entry_t          rd_e;
	slot_ctl_t       pool_ctl;
	logic [IW-1:0]   slot;
	logic            slot_full;

	// datapath terms
	logic            in_fire;
	logic [CW-1:0]   need_in;
	logic [CW-1:0]   rd_start;
	logic [CW-1:0]   rd_end;
	logic            rd_last_head;
	logic            rd_last_nxt;
	logic            rd_last_cur;
	logic            head_fit;
	logic            mid_fit;
	logic            tail_bad;
	logic            f_match;
	logic            out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign rd_e      = entry_t'(ram_rd_data);
	assign need_in   = CW'(request_bytes) + HDR_W;
	assign rd_start  = CW'(rd_e.start);
	assign rd_end    = rd_start + HDR_W + CW'(rd_e.len);

	assign rd_last_head = (rd_e.link == head_q);
	assign rd_last_nxt  = (rd_e.link == nxt_idx_q);
	assign rd_last_cur  = (rd_e.link == cur_idx_q);

	assign head_fit  = (rd_start >= need_q);
	assign mid_fit   = (rd_start >= cur_end_q) && ((rd_start - cur_end_q) >= need_q);
	assign tail_bad  = (cur_end_q > ARENA_W) || ((ARENA_W - cur_end_q) < need_q);
	assign f_match   = ((rd_start + HDR_W) == CW'(off_q));

	// table port steering
	always_comb begin
		ram_rd = 1'b0;
		ram_ra = head_q;
		ram_wr = 1'b0;
		ram_wa = slot;
		ram_wd = '{start: new_start_q, len: AW'(size_q),
			link: self_link_q ? slot : new_link_q};
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && !empty_q) begin
					if (command == CMD_FREE) begin
						ram_rd = 1'b1;
					end else if (request_bytes != '0 && !slot_full) begin
						ram_rd = 1'b1;
					end
				end
			end
			S_A_HEAD: begin
				ram_ra = rd_e.link;
				ram_rd = !head_fit && !rd_last_head;
			end
			S_A_WALK: begin
				ram_ra = rd_e.link;
				ram_rd = !mid_fit && !rd_last_nxt;
			end
			S_F_WALK: begin
				ram_ra = rd_e.link;
				ram_rd = !f_match && !rd_last_cur;
				// unlink from the predecessor
				ram_wa = prev_idx_q;
				ram_wd = '{start: prev_q.start, len: prev_q.len,
					link: rd_last_cur ? prev_idx_q : rd_e.link};
				ram_wr = f_match && !first_q;
			end
			S_PLACE: begin
				ram_wr = 1'b1;
			end
			S_RELINK: begin
				ram_wr = 1'b1;
				ram_wa = cur_idx_q;
				ram_wd = '{start: cur_q.start, len: cur_q.len, link: slot_q};
			end
			S_A_TAIL, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		pool_ctl.fetch = in_fire && (command == CMD_ALLOC);
		pool_ctl.take  = (state_q == S_PLACE);
		pool_ctl.give  = (state_q == S_F_WALK) && f_match;
	end

	ffa_entry_ram #(
		.DEPTH (MAX_BLOCKS),
		.WIDTH (EW),
		.IW    (IW)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (ram_wa),
		.wr_data (ram_wd),
		.rd_en   (ram_rd),
		.rd_addr (ram_ra),
		.rd_data (ram_rd_data)
	);

	ffa_slot_pool #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.IW         (IW),
		.CNT_W      (CNT_W)
	) u_pool (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pool_ctl),
		.give_idx (cur_idx_q),
		.slot     (slot),
		.full     (slot_full)
	);

	// request context and walk registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					size_q      <= request_bytes;
					off_q       <= payload_offset;
					need_q      <= need_in;
					cur_idx_q   <= head_q;
					first_q     <= 1'b1;
					// empty list: new block at offset zero, links to itself
					new_start_q <= '0;
					self_link_q <= 1'b1;
					head_ins_q  <= 1'b1;
					relink_q    <= 1'b0;
					res_off_q   <= '0;
				end
			end
			S_A_HEAD: begin
				if (head_fit) begin
					// gap in front of the first block
					new_start_q <= '0;
					new_link_q  <= head_q;
					self_link_q <= 1'b0;
				end else begin
					cur_q     <= rd_e;
					cur_idx_q <= head_q;
					cur_end_q <= rd_end;
					nxt_idx_q <= rd_e.link;
					head_ins_q <= 1'b0;
				end
			end
			S_A_WALK: begin
				if (mid_fit) begin
					new_start_q <= cur_end_q[AW-1:0];
					new_link_q  <= nxt_idx_q;
					self_link_q <= 1'b0;
					relink_q    <= 1'b1;
				end else begin
					cur_q     <= rd_e;
					cur_idx_q <= nxt_idx_q;
					cur_end_q <= rd_end;
					nxt_idx_q <= rd_e.link;
				end
			end
			S_A_TAIL: begin
				// append after the last block's payload
				new_start_q <= cur_end_q[AW-1:0];
				self_link_q <= 1'b1;
				relink_q    <= 1'b1;
			end
			S_PLACE: begin
				slot_q    <= slot;
				res_off_q <= OFF_W'(CW'(new_start_q) + HDR_W);
			end
			S_F_WALK: begin
				if (!f_match) begin
					prev_q     <= rd_e;
					prev_idx_q <= cur_idx_q;
					cur_idx_q  <= rd_e.link;
					first_q    <= 1'b0;
				end
			end
			S_RELINK, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer, list registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			empty_q     <= 1'b1;
			res_st_q    <= ST_OK;
			out_valid_q <= 1'b0;
			out_st_q    <= ST_OK;
			out_off_q   <= '0;
		end else begin
			// S_DONE reloads the output register itself
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						priority if (command == CMD_FREE) begin
							if (empty_q) begin
								res_st_q <= ST_NOT_FOUND;
								state_q  <= S_DONE;
							end else begin
								res_st_q <= ST_OK;
								state_q  <= S_F_WALK;
							end
						end else if (request_bytes == '0) begin
							res_st_q <= ST_ZERO;
							state_q  <= S_DONE;
						end else if (slot_full) begin
							res_st_q <= ST_FULL;
							state_q  <= S_DONE;
						end else if (empty_q) begin
							if (need_in > ARENA_W) begin
								res_st_q <= ST_NO_SPACE;
								state_q  <= S_DONE;
							end else begin
								res_st_q <= ST_OK;
								state_q  <= S_PLACE;
							end
						end else begin
							res_st_q <= ST_OK;
							state_q  <= S_A_HEAD;
						end
					end
				end
				S_A_HEAD: begin
					priority if (head_fit) begin
						state_q <= S_PLACE;
					end else if (rd_last_head) begin
						state_q <= S_A_TAIL;
					end else begin
						state_q <= S_A_WALK;
					end
				end
				S_A_WALK: begin
					priority if (mid_fit) begin
						state_q <= S_PLACE;
					end else if (rd_last_nxt) begin
						state_q <= S_A_TAIL;
					end else begin
						state_q <= S_A_WALK;
					end
				end
				S_A_TAIL: begin
					if (tail_bad) begin
						res_st_q <= ST_NO_SPACE;
						state_q  <= S_DONE;
					end else begin
						state_q  <= S_PLACE;
					end
				end
				S_PLACE: begin
					if (head_ins_q) begin
						head_q  <= slot;
						empty_q <= 1'b0;
					end
					state_q <= relink_q ? S_RELINK : S_DONE;
				end
				S_RELINK: begin
					state_q <= S_DONE;
				end
				S_F_WALK: begin
					priority if (f_match) begin
						if (first_q) begin
							if (rd_last_cur) begin
								empty_q <= 1'b1;
								head_q  <= '0;
							end else begin
								head_q  <= rd_e.link;
							end
						end
						state_q <= S_DONE;
					end else if (rd_last_cur) begin
						res_st_q <= ST_NOT_FOUND;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_F_WALK;
					end
				end
				S_DONE: begin
					// hand the result over once the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_st_q    <= res_st_q;
						out_off_q   <= (res_st_q == ST_OK) ? res_off_q : '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_st_q;
	assign granted_offset = out_off_q;

	`FFA_ASSERT(a_no_rw_clash, !(ram_wr && ram_rd && (ram_wa == ram_ra)), "table read and write hit one entry")
	`FFA_ASSERT(a_place_has_slot, (state_q == S_PLACE) |-> !slot_full, "block placed with no free slot")
	`FFA_ASSERT_NEXT(a_relink_follows, (state_q == S_PLACE) && relink_q, state_q == S_RELINK, "predecessor link not updated")

endmodule

### tb/tb_first_fit_block_allocator_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_block_allocator_top: directed and random
// allocate/free traffic against an in-bench first-fit block list model.
// Depends on ffa_pkg and the allocator RTL only.
module tb_first_fit_block_allocator_top;
	import ffa_pkg::*;

	localparam int ARENA   = ARENA_BYTES_DEF;
	localparam int HDR     = HEADER_BYTES_DEF;
	localparam int SLOTS   = MAX_BLOCKS_DEF;
	// worst-case walk of the list plus sequencer overhead
	localparam int LATENCY = SLOTS + 8;

	// one expected response per request
	typedef struct packed {
		status_t                 st;
		logic [OFF_W-1:0]        off;
	} reply_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              command;
	logic [REQ_W-1:0]  request_bytes;
	logic [OFF_W-1:0]  payload_offset;
	logic              out_valid;
	logic              out_ready;
	logic [ST_W-1:0]   status;
	logic [OFF_W-1:0]  granted_offset;

	first_fit_block_allocator_top #(
		.ARENA_BYTES  (ARENA),
		.HEADER_BYTES (HDR),
		.MAX_BLOCKS   (SLOTS)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.request_bytes  (request_bytes),
		.payload_offset (payload_offset),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.granted_offset (granted_offset)
	);

	// ---------------------------------------------------------------------
	// Block list model: slot table, address-ordered links, head pointer.
	// A slot whose link points to itself is the tail of the list.
	// ---------------------------------------------------------------------
	int unsigned blk_start [SLOTS];
	int unsigned blk_len   [SLOTS];
	int unsigned blk_link  [SLOTS];
	bit          blk_used  [SLOTS];
	int unsigned head_slot;
	bit          arena_empty;
	int          live_blocks;
	int          peak_blocks;

	reply_t pending_replies[$];

	int  error_count;
	int  request_count;
	int  result_count;
	int  status_seen[5];
	// no idling on either side while set
	bit  calm;

	function automatic void claim_slot(int unsigned slot, int unsigned start,
			int unsigned len, int unsigned link);
		blk_start[slot] = start;
		blk_len[slot]   = len;
		blk_link[slot]  = link;
		blk_used[slot]  = 1'b1;
		live_blocks++;
		if (live_blocks > peak_blocks)
			peak_blocks = live_blocks;
	endfunction

	// first-fit placement: gap before head, gaps between neighbors, tail space
	function automatic reply_t place_block(int unsigned size);
		reply_t      r;
		int unsigned slot;
		int unsigned cur;
		int unsigned nxt;
		int unsigned gap;
		int unsigned need;
		bit          found;
		r.st  = ST_NO_SPACE;
		r.off = '0;
		found = 1'b0;
		slot  = 0;
		if (size == 0) begin
			r.st = ST_ZERO;
			return r;
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (!blk_used[i]) begin
				slot  = i;
				found = 1'b1;
				break;
			end
		end
		// table full wins over any space search
		if (!found) begin
			r.st = ST_FULL;
			return r;
		end
		need = size + HDR;
		if (arena_empty) begin
			if (need > ARENA)
				return r;
			claim_slot(slot, 0, size, slot);
			head_slot   = slot;
			arena_empty = 1'b0;
			r.st  = ST_OK;
			r.off = OFF_W'(HDR);
			return r;
		end
		cur = head_slot;
		if (blk_start[cur] >= need) begin
			claim_slot(slot, 0, size, cur);
			head_slot = slot;
			r.st  = ST_OK;
			r.off = OFF_W'(HDR);
			return r;
		end
		for (int steps = 0; steps < SLOTS; steps++) begin
			nxt = blk_link[cur];
			gap = blk_start[cur] + HDR + blk_len[cur];
			if (nxt == cur) begin
				// tail: space runs from end of last payload to end of arena
				if (gap > ARENA || ARENA - gap < need)
					return r;
				claim_slot(slot, gap, size, slot);
				blk_link[cur] = slot;
				r.st  = ST_OK;
				r.off = OFF_W'(gap + HDR);
				return r;
			end
			if (blk_start[nxt] >= gap && blk_start[nxt] - gap >= need) begin
				claim_slot(slot, gap, size, nxt);
				blk_link[cur] = slot;
				r.st  = ST_OK;
				r.off = OFF_W'(gap + HDR);
				return r;
			end
			cur = nxt;
		end
		return r;
	endfunction

	// unlink the block whose payload starts at off
	function automatic reply_t release_block(int unsigned off);
		reply_t      r;
		int unsigned cur;
		int unsigned nxt;
		int unsigned prev;
		bit          first;
		bit          last;
		r.st  = ST_NOT_FOUND;
		r.off = '0;
		prev  = 0;
		first = 1'b1;
		if (arena_empty)
			return r;
		cur = head_slot;
		for (int steps = 0; steps < SLOTS; steps++) begin
			nxt  = blk_link[cur];
			last = (nxt == cur);
			if (blk_start[cur] + HDR == off) begin
				blk_used[cur] = 1'b0;
				live_blocks--;
				if (first) begin
					if (last) begin
						arena_empty = 1'b1;
						head_slot   = 0;
					end else begin
						head_slot = nxt;
					end
				end else begin
					blk_link[prev] = last ? prev : nxt;
				end
				r.st = ST_OK;
				return r;
			end
			if (last)
				break;
			prev  = cur;
			cur   = nxt;
			first = 1'b0;
		end
		return r;
	endfunction

	// payload offset of a random live block, or any offset if none is live
	function automatic int unsigned live_offset();
		int unsigned slots[$];
		for (int i = 0; i < SLOTS; i++)
			if (blk_used[i])
				slots.push_back(i);
		if (slots.size() == 0)
			return $urandom_range(0, 4095);
		return blk_start[slots[$urandom_range(0, slots.size() - 1)]] + HDR;
	endfunction

	// ---------------------------------------------------------------------
	// Clock, reset, initial input values
	// ---------------------------------------------------------------------
	task automatic arst_n_release();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		command        = CMD_ALLOC;
		request_bytes  = '0;
		payload_offset = '0;
		arst_n_release();
	end

	// Output side back-pressure: random low bursts, ready stretches in
	// between. Held high once calm is set.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Response checker: every output transfer is matched against the oldest
	// predicted reply, field by field.
	// ---------------------------------------------------------------------
	initial begin
		reply_t exp_r;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				result_count++;
				if (pending_replies.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result, status %0d granted_offset %0d",
						$time, status, granted_offset);
				end else begin
					exp_r = pending_replies.pop_front();
					if (status !== exp_r.st) begin
						error_count++;
						$display("%0t: status expected %0d (%s) actual %0d",
							$time, exp_r.st, exp_r.st.name(), status);
					end
					if (granted_offset !== exp_r.off) begin
						error_count++;
						$display("%0t: granted_offset expected %0d actual %0d",
							$time, exp_r.off, granted_offset);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Request driver. Valid stays high across back-to-back transfers; a gap
	// lowers it for a random burst first. Prediction is made at the edge
	// where the transfer happens, so the model sees requests in DUT order.
	// Field values are cut to the port widths before driving and predicting.
	// ---------------------------------------------------------------------
	task automatic issue_request(input logic cmd, input int unsigned bytes,
			input int unsigned off);
		reply_t           r;
		logic [REQ_W-1:0] req_b;
		logic [OFF_W-1:0] req_o;
		req_b = REQ_W'(bytes);
		req_o = OFF_W'(off);
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		command        <= cmd;
		request_bytes  <= req_b;
		payload_offset <= req_o;
		in_valid       <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (cmd == CMD_ALLOC)
			r = place_block(32'(req_b));
		else
			r = release_block(32'(req_o));
		pending_replies.push_back(r);
		status_seen[r.st]++;
		request_count++;
	endtask

	// stop sending and let every outstanding reply come back
	task automatic wait_for_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// empty list, size extremes, exact fit, gap reuse, ignored fields
	task automatic test_directed_corners();
		issue_request(CMD_FREE, '0, '0);                     // free on empty list
		issue_request(CMD_FREE, '1, '1);
		issue_request(CMD_ALLOC, '0, '1);                    // zero size
		issue_request(CMD_ALLOC, '1, '0);                    // far too large
		issue_request(CMD_ALLOC, ARENA - HDR + 1, '0);       // one byte too many
		issue_request(CMD_ALLOC, ARENA - HDR, '0);           // fills arena exactly
		issue_request(CMD_ALLOC, 1, '0);                     // nothing left
		issue_request(CMD_FREE, '1, HDR);
		issue_request(CMD_FREE, '0, HDR);                    // already released
		issue_request(CMD_ALLOC, 100, '1);                   // offset field ignored
		issue_request(CMD_ALLOC, 200, 12'h555);
		issue_request(CMD_ALLOC, 50, 12'haaa);
		issue_request(CMD_FREE, 13'h0aaa, 2 * HDR + 100);    // middle block
		issue_request(CMD_ALLOC, 150, '0);                   // lands in middle gap
		issue_request(CMD_FREE, 13'h1555, HDR);              // head block
		issue_request(CMD_ALLOC, 10, '0);                    // gap before head
		issue_request(CMD_FREE, '0, HDR + 1);                // near miss
		issue_request(CMD_ALLOC, 3000, '0);                  // tail append
		issue_request(CMD_ALLOC, 1000, '0);                  // tail space too short
		issue_request(CMD_FREE, '0, live_offset());
		issue_request(CMD_FREE, '0, live_offset());
	endtask

	// fill all slots, then full/zero precedence and slot reuse
	task automatic test_table_full();
		while (live_blocks != 0)
			issue_request(CMD_FREE, $urandom, live_offset());
		for (int i = 0; i < SLOTS; i++)
			issue_request(CMD_ALLOC, $urandom_range(1, 30), $urandom);
		issue_request(CMD_ALLOC, 1, '0);                     // table full
		issue_request(CMD_ALLOC, '0, '0);                    // zero size checked first
		issue_request(CMD_ALLOC, '1, '0);                    // full before space search
		issue_request(CMD_FREE, '0, live_offset());
		issue_request(CMD_ALLOC, 5, '0);                     // reuses freed slot
		issue_request(CMD_FREE, '0, 12'hfff);                // long walk, no match
		for (int i = 0; i < SLOTS / 2; i++)
			issue_request(CMD_FREE, $urandom, live_offset());
	endtask

	// Mostly well-formed traffic: allocs of mostly small sizes and frees of
	// live blocks; the rest is zero or random-size allocs and stray frees.
	task automatic test_random_traffic(input int count);
		int unsigned pick;
		int unsigned bytes;
		for (int n = 0; n < count; n++) begin
			if (n == count / 2)
				wait_for_drain();
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				bytes = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 1500)
				                                    : $urandom_range(1, 150);
				issue_request(CMD_ALLOC, bytes, $urandom);
			end else if (pick < 58) begin
				bytes = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8191);
				issue_request(CMD_ALLOC, bytes, $urandom);
			end else if (pick < 92) begin
				issue_request(CMD_FREE, $urandom, live_offset());
			end else begin
				issue_request(CMD_FREE, $urandom, $urandom_range(0, 4095));
			end
		end
	endtask

	// last stretch with both sides always ready
	task automatic test_back_to_back();
		calm = 1'b1;
		test_random_traffic(80);
	endtask

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------
	initial begin
		for (int i = 0; i < SLOTS; i++)
			blk_used[i] = 1'b0;
		head_slot     = 0;
		arena_empty   = 1'b1;
		live_blocks   = 0;
		peak_blocks   = 0;
		error_count   = 0;
		request_count = 0;
		result_count  = 0;
		calm          = 1'b0;
		for (int i = 0; i < 5; i++)
			status_seen[i] = 0;
		@(posedge arst_n);

		test_directed_corners();
		test_table_full();
		test_random_traffic(300);
		test_back_to_back();

		wait_for_drain();
		// catch any stray result after the last expected one
		repeat (LATENCY) @(posedge clk);

		$display("Covered %0d requests, %0d results, peak %0d live blocks", request_count,
			result_count, peak_blocks);
		$display("Statuses: ok %0d, no space %0d, zero %0d, not found %0d, full %0d",
			status_seen[ST_OK], status_seen[ST_NO_SPACE], status_seen[ST_ZERO],
			status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog: a hung handshake ends the run
	initial begin
		#5_000_000;
		$display("%0t: timeout, %0d replies outstanding", $time, pending_replies.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
